// ----- src/cube_map_face_select_assert.svh -----
// Assertion macros shared by the cube map face select RTL.
`ifndef CUBE_MAP_FACE_SELECT_ASSERT_SVH
`define CUBE_MAP_FACE_SELECT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CMFS_ASSERT_NOW(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define CMFS_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ----- src/cmfs_pkg.sv -----
// Shared types, constants and helpers for the cube map face select pipeline.
package cmfs_pkg;

   // Size registers and texel integer part
   localparam int SIZE_BITS      = 13;
   localparam int INT_BITS       = 12;
   localparam int SIZE_MIN       = 3;
   localparam int SIZE_MAX       = 4096;
   localparam int RESET_SIZE     = 258;
   localparam int CSR_INDEX_BITS = 1;
   localparam int FACE_BITS      = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FACE_HEIGHT = 1'b0,
      CSR_FACE_WIDTH  = 1'b1
   } csr_index_type;

   // Face codes
   localparam logic [FACE_BITS-1:0] FACE_POS_X = 3'd0;
   localparam logic [FACE_BITS-1:0] FACE_NEG_X = 3'd1;
   localparam logic [FACE_BITS-1:0] FACE_POS_Y = 3'd2;
   localparam logic [FACE_BITS-1:0] FACE_NEG_Y = 3'd3;
   localparam logic [FACE_BITS-1:0] FACE_POS_Z = 3'd4;
   localparam logic [FACE_BITS-1:0] FACE_NEG_Z = 3'd5;

   // Per-request tag that rides along the pipeline
   typedef struct packed {
      logic                 hit;
      logic [FACE_BITS-1:0] face;
   } face_meta_type;

   // Clamp a size register to the legal range and return size - 2
   function automatic logic [INT_BITS-1:0] size_span(input logic [SIZE_BITS-1:0] size);
      logic [INT_BITS-1:0] res;
      if (size < SIZE_BITS'(SIZE_MIN)) begin
         res = INT_BITS'(SIZE_MIN - 2);
      end else if (size > SIZE_BITS'(SIZE_MAX)) begin
         res = INT_BITS'(SIZE_MAX - 2);
      end else begin
         res = INT_BITS'(size - SIZE_BITS'(2));
      end
      return res;
   endfunction

endpackage

// ----- src/cmfs_select.sv -----
// Stage 1: major axis pick, face code, minor numerators offset into spans.
module cmfs_select #(
   parameter int CB = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic signed [CB-1:0]   in_x,
   input  logic signed [CB-1:0]   in_y,
   input  logic signed [CB-1:0]   in_z,
   input  logic                   stall_in,
   output logic                   stall_out,
   output logic                   out_valid,
   output cmfs_pkg::face_meta_type out_meta,
   output logic [CB-1:0]          out_m,
   output logic [CB:0]            out_span_t,
   output logic [CB:0]            out_span_s
);
   import cmfs_pkg::*;

   logic [CB-1:0] ax, ay, az;
   logic          xmax, ymax, zmax;
   logic          xpos, ypos, zpos;
   face_meta_type meta_in;
   logic [CB-1:0] m_in;
   logic [CB-1:0] s_src, t_src;
   logic          s_neg, t_neg;
   logic signed [CB+1:0] m_ext, s_ext, t_ext, s_sum, t_sum;
   logic [CB:0]   span_s_in, span_t_in;

   logic          valid_ff;
   face_meta_type meta_ff;
   logic [CB-1:0] m_ff;
   logic [CB:0]   span_t_ff, span_s_ff;
   logic          load;

   // Magnitudes (most negative value maps to 2^(CB-1), still fits)
   assign ax = in_x[CB-1] ? CB'(~in_x + 1'b1) : in_x;
   assign ay = in_y[CB-1] ? CB'(~in_y + 1'b1) : in_y;
   assign az = in_z[CB-1] ? CB'(~in_z + 1'b1) : in_z;

   assign xmax = (ax >= ay) && (ax >= az);
   assign ymax = (ay >= ax) && (ay >= az);
   assign zmax = (az >= ax) && (az >= ay);

   assign xpos = !in_x[CB-1] && (in_x != '0);
   assign ypos = !in_y[CB-1] && (in_y != '0);
   assign zpos = !in_z[CB-1] && (in_z != '0);

   // Face priority +x, -x, +y, -y, +z, -z
   always_comb begin
      meta_in = '0;
      m_in    = '0;
      s_src   = '0;
      t_src   = '0;
      s_neg   = 1'b0;
      t_neg   = 1'b0;
      if (xpos && xmax) begin
         meta_in = '{hit: 1'b1, face: FACE_POS_X};
         m_in = ax; s_src = in_z; s_neg = 1'b1; t_src = in_y; t_neg = 1'b1;
      end else if (in_x[CB-1] && xmax) begin
         meta_in = '{hit: 1'b1, face: FACE_NEG_X};
         m_in = ax; s_src = in_z; s_neg = 1'b0; t_src = in_y; t_neg = 1'b1;
      end else if (ypos && ymax) begin
         meta_in = '{hit: 1'b1, face: FACE_POS_Y};
         m_in = ay; s_src = in_x; s_neg = 1'b0; t_src = in_z; t_neg = 1'b0;
      end else if (in_y[CB-1] && ymax) begin
         meta_in = '{hit: 1'b1, face: FACE_NEG_Y};
         m_in = ay; s_src = in_x; s_neg = 1'b0; t_src = in_z; t_neg = 1'b1;
      end else if (zpos && zmax) begin
         meta_in = '{hit: 1'b1, face: FACE_POS_Z};
         m_in = az; s_src = in_x; s_neg = 1'b0; t_src = in_y; t_neg = 1'b1;
      end else if (in_z[CB-1] && zmax) begin
         meta_in = '{hit: 1'b1, face: FACE_NEG_Z};
         m_in = az; s_src = in_x; s_neg = 1'b1; t_src = in_y; t_neg = 1'b1;
      end
   end

   // span = m +/- component, always within [0, 2m]
   assign m_ext = $signed({2'b00, m_in});
   assign s_ext = $signed({{2{s_src[CB-1]}}, s_src});
   assign t_ext = $signed({{2{t_src[CB-1]}}, t_src});
   assign s_sum = s_neg ? (m_ext - s_ext) : (m_ext + s_ext);
   assign t_sum = t_neg ? (m_ext - t_ext) : (m_ext + t_ext);
   assign span_s_in = s_sum[CB:0];
   assign span_t_in = t_sum[CB:0];

   // Stage register with local hold
   assign stall_out = valid_ff && stall_in;
   assign load      = !stall_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         meta_ff   <= meta_in;
         m_ff      <= m_in;
         span_t_ff <= span_t_in;
         span_s_ff <= span_s_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_meta   = meta_ff;
   assign out_m      = m_ff;
   assign out_span_t = span_t_ff;
   assign out_span_s = span_s_ff;

endmodule

// ----- src/cmfs_scale.sv -----
// Stage 2: scale spans by (size - 2) and set up the long division.
module cmfs_scale #(
   parameter int CB = 16,
   parameter int F  = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  cmfs_pkg::face_meta_type      in_meta,
   input  logic [CB-1:0]                in_m,
   input  logic [CB:0]                  in_span_t,
   input  logic [CB:0]                  in_span_s,
   input  logic [cmfs_pkg::INT_BITS-1:0] sm2_h,
   input  logic [cmfs_pkg::INT_BITS-1:0] sm2_w,
   input  logic                         stall_in,
   output logic                         stall_out,
   output logic                         out_valid,
   output cmfs_pkg::face_meta_type      out_meta,
   output logic [CB:0]                  out_d,
   output logic [CB:0]                  out_rem_row,
   output logic [cmfs_pkg::INT_BITS+F-1:0] out_lo_row,
   output logic [CB:0]                  out_rem_col,
   output logic [cmfs_pkg::INT_BITS+F-1:0] out_lo_col
);
   import cmfs_pkg::*;

   localparam int DW = CB + 1;
   localparam int QW = INT_BITS + F;
   localparam int PW = INT_BITS + DW;

   logic [PW-1:0] prod_row, prod_col;
   logic          valid_ff;
   face_meta_type meta_ff;
   logic [DW-1:0] d_ff, rem_row_ff, rem_col_ff;
   logic [QW-1:0] lo_row_ff, lo_col_ff;
   logic          load;

   // (size - 2) * span, one multiply per coordinate
   assign prod_row = PW'(sm2_h) * PW'(in_span_t);
   assign prod_col = PW'(sm2_w) * PW'(in_span_s);

   assign stall_out = valid_ff && stall_in;
   assign load      = !stall_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   // Dividend = prod << F; its top DW bits seed the remainder (below 2m)
   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         meta_ff    <= in_meta;
         d_ff       <= {in_m, 1'b0};
         rem_row_ff <= prod_row[PW-1:INT_BITS];
         rem_col_ff <= prod_col[PW-1:INT_BITS];
         lo_row_ff  <= {prod_row[INT_BITS-1:0], {F{1'b0}}};
         lo_col_ff  <= {prod_col[INT_BITS-1:0], {F{1'b0}}};
      end
   end

   assign out_valid   = valid_ff;
   assign out_meta    = meta_ff;
   assign out_d       = d_ff;
   assign out_rem_row = rem_row_ff;
   assign out_lo_row  = lo_row_ff;
   assign out_rem_col = rem_col_ff;
   assign out_lo_col  = lo_col_ff;

endmodule

// ----- src/cmfs_div_stage.sv -----
// One stage of the pipelined restoring divider (row and column together).
module cmfs_div_stage #(
   parameter int DW    = 17,
   parameter int QW    = 20,
   parameter int STEPS = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  cmfs_pkg::face_meta_type in_meta,
   input  logic [DW-1:0]           in_d,
   input  logic [DW-1:0]           in_rem_row,
   input  logic [QW-1:0]           in_lo_row,
   input  logic [DW-1:0]           in_rem_col,
   input  logic [QW-1:0]           in_lo_col,
   input  logic                    stall_in,
   output logic                    stall_out,
   output logic                    out_valid,
   output cmfs_pkg::face_meta_type out_meta,
   output logic [DW-1:0]           out_d,
   output logic [DW-1:0]           out_rem_row,
   output logic [QW-1:0]           out_lo_row,
   output logic [DW-1:0]           out_rem_col,
   output logic [QW-1:0]           out_lo_col
);
   import cmfs_pkg::*;

   // STEPS shift-compare-subtract steps; quotient bits enter lo at the bottom
   function automatic logic [DW+QW-1:0] div_steps(input logic [DW-1:0] d,
                                                  input logic [DW-1:0] rem_i,
                                                  input logic [QW-1:0] lo_i);
      logic [DW-1:0] rem;
      logic [QW-1:0] lo;
      logic [DW:0]   trial;
      rem = rem_i;
      lo  = lo_i;
      for (int i = 0; i < STEPS; i++) begin
         trial = {rem, lo[QW-1]};
         lo    = {lo[QW-2:0], 1'b0};
         if (trial >= {1'b0, d}) begin
            trial = trial - {1'b0, d};
            lo[0] = 1'b1;
         end
         rem = trial[DW-1:0];
      end
      return {rem, lo};
   endfunction

   logic [DW+QW-1:0] row_in, col_in;
   logic             valid_ff;
   face_meta_type    meta_ff;
   logic [DW-1:0]    d_ff, rem_row_ff, rem_col_ff;
   logic [QW-1:0]    lo_row_ff, lo_col_ff;
   logic             load;

   assign row_in = div_steps(in_d, in_rem_row, in_lo_row);
   assign col_in = div_steps(in_d, in_rem_col, in_lo_col);

   assign stall_out = valid_ff && stall_in;
   assign load      = !stall_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         meta_ff    <= in_meta;
         d_ff       <= in_d;
         rem_row_ff <= row_in[DW+QW-1:QW];
         lo_row_ff  <= row_in[QW-1:0];
         rem_col_ff <= col_in[DW+QW-1:QW];
         lo_col_ff  <= col_in[QW-1:0];
      end
   end

   assign out_valid   = valid_ff;
   assign out_meta    = meta_ff;
   assign out_d       = d_ff;
   assign out_rem_row = rem_row_ff;
   assign out_lo_row  = lo_row_ff;
   assign out_rem_col = rem_col_ff;
   assign out_lo_col  = lo_col_ff;

endmodule

// ----- src/cmfs_out.sv -----
// Last stage: add the border offset, saturate, and hold the response register.
module cmfs_out #(
   parameter int F = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  cmfs_pkg::face_meta_type      in_meta,
   input  logic [cmfs_pkg::INT_BITS+F-1:0] in_q_row,
   input  logic [cmfs_pkg::INT_BITS+F-1:0] in_q_col,
   input  logic [cmfs_pkg::INT_BITS-1:0] sm2_h,
   input  logic [cmfs_pkg::INT_BITS-1:0] sm2_w,
   input  logic                         stall_in,
   output logic                         stall_out,
   output logic                         out_valid,
   output logic                         out_valid_res,
   output logic [cmfs_pkg::FACE_BITS-1:0] out_face,
   output logic [cmfs_pkg::INT_BITS+F-1:0] out_row_pos,
   output logic [cmfs_pkg::INT_BITS+F-1:0] out_col_pos
);
   import cmfs_pkg::*;

   localparam int QW = INT_BITS + F;
   localparam logic [QW:0] ONE = (QW+1)'(1) << F;

   // pos = 1.0 + q, held inside [1.0, size - 1]
   function automatic logic [QW-1:0] place(input logic [QW-1:0] q,
                                           input logic [INT_BITS-1:0] sm2);
      logic [QW:0] pos;
      logic [QW:0] hi;
      pos = {1'b0, q} + ONE;
      hi  = ((QW+1)'(sm2) + (QW+1)'(1)) << F;
      if (pos < ONE) begin
         pos = ONE;
      end
      if (pos > hi) begin
         pos = hi;
      end
      return pos[QW-1:0];
   endfunction

   logic [QW-1:0]        row_in, col_in;
   logic                 valid_ff, valid_res_ff;
   logic [FACE_BITS-1:0] face_ff;
   logic [QW-1:0]        row_ff, col_ff;
   logic                 load;

   // Zero vector reports all-zero fields
   assign row_in = in_meta.hit ? place(in_q_row, sm2_h) : '0;
   assign col_in = in_meta.hit ? place(in_q_col, sm2_w) : '0;

   assign stall_out = valid_ff && stall_in;
   assign load      = !stall_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         valid_res_ff <= in_meta.hit;
         face_ff      <= in_meta.hit ? in_meta.face : FACE_POS_X;
         row_ff       <= row_in;
         col_ff       <= col_in;
      end
   end

   assign out_valid     = valid_ff;
   assign out_valid_res = valid_res_ff;
   assign out_face      = face_ff;
   assign out_row_pos   = row_ff;
   assign out_col_pos   = col_ff;

endmodule

// ----- src/cube_map_face_select.sv -----
// Top level of the cube map face select pipeline: size registers and stage chain.
//
//  Channel  Direction  Handshake             Payload
//  req      in         req_valid/req_stall   req_dir_x, req_dir_y, req_dir_z
//  rsp      out        rsp_valid/rsp_stall   rsp_valid_res, rsp_face, rsp_row_pos, rsp_col_pos
//  csr      in         csr_write             csr_index, csr_wdata
//
//  One request enters per cycle while req_stall is low. The stages are, in order: select,
//  multiply, one divider stage per two quotient bits, output.
//  Most stages belong to the divider, which retires two quotient bits per stage.
//  Reset clears the stage valid bits and loads both sizes with 258; no clearing pass.
//  A stage holds only while it is full and the stage after it holds, so bubbles
//  close up under rsp_stall and new requests keep entering until the pipe is full.
`include "cube_map_face_select_assert.svh"

module cube_map_face_select #(
   parameter int COMPONENT_BITS  = 16,
   parameter int COORD_FRAC_BITS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [COMPONENT_BITS-1:0]      req_dir_x,
   input  logic signed [COMPONENT_BITS-1:0]      req_dir_y,
   input  logic signed [COMPONENT_BITS-1:0]      req_dir_z,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_valid_res,
   output logic [cmfs_pkg::FACE_BITS-1:0]        rsp_face,
   output logic [cmfs_pkg::INT_BITS+COORD_FRAC_BITS-1:0] rsp_row_pos,
   output logic [cmfs_pkg::INT_BITS+COORD_FRAC_BITS-1:0] rsp_col_pos,
   input  logic                                  csr_write,
   input  logic [cmfs_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [cmfs_pkg::SIZE_BITS-1:0]        csr_wdata
);
   import cmfs_pkg::*;

   localparam int CB   = COMPONENT_BITS;
   localparam int F    = COORD_FRAC_BITS;
   localparam int DW   = CB + 1;
   localparam int QW   = INT_BITS + F;
   localparam int NSTG = (QW + 1) / 2;

   // Size registers
   logic [SIZE_BITS-1:0] face_height_ff, face_width_ff;
   logic [INT_BITS-1:0]  sm2_h, sm2_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         face_height_ff <= SIZE_BITS'(RESET_SIZE);
         face_width_ff  <= SIZE_BITS'(RESET_SIZE);
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_FACE_HEIGHT: begin
               face_height_ff <= csr_wdata;
            end
            CSR_FACE_WIDTH: begin
               face_width_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   assign sm2_h = size_span(face_height_ff);
   assign sm2_w = size_span(face_width_ff);

   // Stage 1: face select
   logic          sel_valid, sel_stall_in;
   face_meta_type sel_meta;
   logic [CB-1:0] sel_m;
   logic [CB:0]   sel_span_t, sel_span_s;

   cmfs_select #(.CB(CB)) u_select (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_x       (req_dir_x),
      .in_y       (req_dir_y),
      .in_z       (req_dir_z),
      .stall_in   (sel_stall_in),
      .stall_out  (req_stall),
      .out_valid  (sel_valid),
      .out_meta   (sel_meta),
      .out_m      (sel_m),
      .out_span_t (sel_span_t),
      .out_span_s (sel_span_s)
   );

   // Divider chain; index 0 is the multiplier stage output
   logic [NSTG:0] dv;
   logic [NSTG:0] dst;
   face_meta_type dmeta [NSTG+1];
   logic [DW-1:0] dd    [NSTG+1];
   logic [DW-1:0] drr   [NSTG+1];
   logic [DW-1:0] drc   [NSTG+1];
   logic [QW-1:0] dlr   [NSTG+1];
   logic [QW-1:0] dlc   [NSTG+1];

   // Stage 2: multiply
   cmfs_scale #(.CB(CB), .F(F)) u_scale (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (sel_valid),
      .in_meta     (sel_meta),
      .in_m        (sel_m),
      .in_span_t   (sel_span_t),
      .in_span_s   (sel_span_s),
      .sm2_h       (sm2_h),
      .sm2_w       (sm2_w),
      .stall_in    (dst[0]),
      .stall_out   (sel_stall_in),
      .out_valid   (dv[0]),
      .out_meta    (dmeta[0]),
      .out_d       (dd[0]),
      .out_rem_row (drr[0]),
      .out_lo_row  (dlr[0]),
      .out_rem_col (drc[0]),
      .out_lo_col  (dlc[0])
   );

   // Divider stages, two quotient bits each (one in an odd tail)
   for (genvar k = 0; k < NSTG; k++) begin : g_div
      localparam int STEPS = ((QW - 2*k) >= 2) ? 2 : 1;
      cmfs_div_stage #(.DW(DW), .QW(QW), .STEPS(STEPS)) u_div (
         .clock       (clock),
         .reset       (reset),
         .in_valid    (dv[k]),
         .in_meta     (dmeta[k]),
         .in_d        (dd[k]),
         .in_rem_row  (drr[k]),
         .in_lo_row   (dlr[k]),
         .in_rem_col  (drc[k]),
         .in_lo_col   (dlc[k]),
         .stall_in    (dst[k+1]),
         .stall_out   (dst[k]),
         .out_valid   (dv[k+1]),
         .out_meta    (dmeta[k+1]),
         .out_d       (dd[k+1]),
         .out_rem_row (drr[k+1]),
         .out_lo_row  (dlr[k+1]),
         .out_rem_col (drc[k+1]),
         .out_lo_col  (dlc[k+1])
      );
   end

   // Output stage
   cmfs_out #(.F(F)) u_out (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (dv[NSTG]),
      .in_meta       (dmeta[NSTG]),
      .in_q_row      (dlr[NSTG]),
      .in_q_col      (dlc[NSTG]),
      .sm2_h         (sm2_h),
      .sm2_w         (sm2_w),
      .stall_in      (rsp_stall),
      .stall_out     (dst[NSTG]),
      .out_valid     (rsp_valid),
      .out_valid_res (rsp_valid_res),
      .out_face      (rsp_face),
      .out_row_pos   (rsp_row_pos),
      .out_col_pos   (rsp_col_pos)
   );

   // Checks
   `CMFS_ASSERT_NOW(a_zero_vector_clear, clock, reset, rsp_valid && !rsp_valid_res,
      (rsp_face == FACE_POS_X) && (rsp_row_pos == '0) && (rsp_col_pos == '0),
      "zero vector response carries nonzero fields")
   `CMFS_ASSERT_NOW(a_face_code, clock, reset, rsp_valid && rsp_valid_res,
      rsp_face <= FACE_NEG_Z, "face code out of range")
   `CMFS_ASSERT_NOW(a_pos_range, clock, reset, rsp_valid && rsp_valid_res,
      (rsp_row_pos >= (QW'(1) << F)) && (rsp_col_pos >= (QW'(1) << F)) &&
      (rsp_row_pos <= (QW'(sm2_h) + QW'(1)) << F) &&
      (rsp_col_pos <= (QW'(sm2_w) + QW'(1)) << F),
      "texel position outside bordered face")
   `CMFS_ASSERT_NEXT(a_accept_lands, clock, reset, req_valid && !req_stall,
      sel_valid, "accepted request missing from first stage")

endmodule

// ----- dv/cube_map_face_select_tb.sv -----
// Self-checking testbench for the cube map face select pipeline.
`timescale 1ns / 100ps

module cube_map_face_select_tb;
   import cmfs_pkg::*;

   localparam int DIR_BITS     = 16;
   localparam int FRAC_BITS    = 8;
   localparam int POS_W        = INT_BITS + FRAC_BITS;
   localparam int PIPE_LATENCY = 13;
   localparam int QUIET_LIMIT  = 2000;
   localparam int SWEEP_CHUNK  = 240;

   typedef struct packed {
      logic                 valid_res;
      logic [FACE_BITS-1:0] face;
      logic [POS_W-1:0]     row_pos;
      logic [POS_W-1:0]     col_pos;
   } texel_hit_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [DIR_BITS-1:0] req_dir_x = '0;
   logic signed [DIR_BITS-1:0] req_dir_y = '0;
   logic signed [DIR_BITS-1:0] req_dir_z = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic                       rsp_valid_res;
   logic [FACE_BITS-1:0]       rsp_face;
   logic [POS_W-1:0]           rsp_row_pos;
   logic [POS_W-1:0]           rsp_col_pos;
   logic                       csr_write = 1'b0;
   csr_index_type              csr_index = CSR_FACE_HEIGHT;
   logic [SIZE_BITS-1:0]       csr_wdata = '0;

   // Predictor copy of the size registers
   logic [SIZE_BITS-1:0] face_height_reg = SIZE_BITS'(RESET_SIZE);
   logic [SIZE_BITS-1:0] face_width_reg  = SIZE_BITS'(RESET_SIZE);

   texel_hit_type expected_texels[$];
   int            mismatch_count = 0;
   int            quiet_cycles   = 0;
   int            req_idle_pct   = 0;
   int            rsp_stall_pct  = 0;

   cube_map_face_select uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_dir_x     (req_dir_x),
      .req_dir_y     (req_dir_y),
      .req_dir_z     (req_dir_z),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_valid_res (rsp_valid_res),
      .rsp_face      (rsp_face),
      .rsp_row_pos   (rsp_row_pos),
      .rsp_col_pos   (rsp_col_pos),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #5 clock = ~clock;

   // Map one minor component onto the bordered face, Q12.8
   function automatic logic [POS_W-1:0] texel_pos(input logic [SIZE_BITS-1:0] size_reg,
                                                 input longint num, input longint m);
      longint size;
      longint q;
      longint pos;
      longint hi;
      size = size_reg;
      if (size < SIZE_MIN) size = SIZE_MIN;
      else if (size > SIZE_MAX) size = SIZE_MAX;
      q   = (((size - 2) * (num + m)) << FRAC_BITS) / (2 * m);
      pos = (longint'(1) << FRAC_BITS) + q;
      hi  = (size - 1) << FRAC_BITS;
      if (pos < (longint'(1) << FRAC_BITS)) pos = longint'(1) << FRAC_BITS;
      if (pos > hi) pos = hi;
      return pos[POS_W-1:0];
   endfunction

   // Major axis pick, minor components and face coordinates
   function automatic texel_hit_type project_direction(input logic signed [DIR_BITS-1:0] dx,
                                                       input logic signed [DIR_BITS-1:0] dy,
                                                       input logic signed [DIR_BITS-1:0] dz,
                                                       input logic [SIZE_BITS-1:0] height,
                                                       input logic [SIZE_BITS-1:0] width);
      longint        x, y, z, ax, ay, az, s, t, m;
      bit            xmax, ymax, zmax;
      texel_hit_type hit;
      x = dx;
      y = dy;
      z = dz;
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      az = (z < 0) ? -z : z;
      xmax = (ax >= ay) && (ax >= az);
      ymax = (ay >= ax) && (ay >= az);
      zmax = (az >= ax) && (az >= ay);
      hit = '0;
      s = 0;
      t = 0;
      m = 0;
      // first face in +x,-x,+y,-y,+z,-z order wins ties
      if (x > 0 && xmax) begin
         hit.face = FACE_POS_X; s = -z; t = -y; m = ax;
      end else if (x < 0 && xmax) begin
         hit.face = FACE_NEG_X; s = z; t = -y; m = ax;
      end else if (y > 0 && ymax) begin
         hit.face = FACE_POS_Y; s = x; t = z; m = ay;
      end else if (y < 0 && ymax) begin
         hit.face = FACE_NEG_Y; s = x; t = -z; m = ay;
      end else if (z > 0 && zmax) begin
         hit.face = FACE_POS_Z; s = x; t = -y; m = az;
      end else if (z < 0 && zmax) begin
         hit.face = FACE_NEG_Z; s = -x; t = -y; m = az;
      end
      // zero vector leaves everything cleared
      if (m != 0) begin
         hit.valid_res = 1'b1;
         hit.row_pos   = texel_pos(height, t, m);
         hit.col_pos   = texel_pos(width, s, m);
      end
      return hit;
   endfunction

   // Receiver stall
   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < rsp_stall_pct);
   end

   task automatic report_mismatch(input string what, input texel_hit_type want,
                                  input texel_hit_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t %s: expected valid=%0d face=%0d row=%0h col=%0h",
                  $realtime, what, want.valid_res, want.face, want.row_pos, want.col_pos,
                  ", got valid=%0d face=%0d row=%0h col=%0h",
                  got.valid_res, got.face, got.row_pos, got.col_pos);
      end
   endtask

   // Response checker
   always @(posedge clock) begin
      texel_hit_type got;
      texel_hit_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_valid_res, rsp_face, rsp_row_pos, rsp_col_pos};
         if (expected_texels.size() == 0) begin
            report_mismatch("unexpected response", '0, got);
         end else begin
            want = expected_texels.pop_front();
            if (got.valid_res !== want.valid_res || got.face !== want.face ||
                got.row_pos !== want.row_pos || got.col_pos !== want.col_pos) begin
               report_mismatch("response mismatch", want, got);
            end
         end
      end
   end

   // Watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // One request; entered and left at a falling edge, valid left high
   task automatic send_dir(input logic signed [DIR_BITS-1:0] x,
                           input logic signed [DIR_BITS-1:0] y,
                           input logic signed [DIR_BITS-1:0] z);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_dir_x <= x;
      req_dir_y <= y;
      req_dir_z <= z;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_texels.push_back(project_direction(x, y, z, face_height_reg, face_width_reg));
      @(negedge clock);
   endtask

   // Stop sending and wait for the pipe to empty
   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (expected_texels.size() != 0) @(negedge clock);
      repeat (PIPE_LATENCY) @(negedge clock);
   endtask

   task automatic write_size(input csr_index_type idx, input logic [SIZE_BITS-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_FACE_HEIGHT) face_height_reg = value;
      else face_width_reg = value;
      @(negedge clock);
   endtask

   function automatic logic signed [DIR_BITS-1:0] corner_component();
      case ($urandom_range(0, 5))
         0:       return 16'sh8000;
         1:       return 16'sh8001;
         2:       return -16'sd1;
         3:       return 16'sd0;
         4:       return 16'sd1;
         default: return 16'sh7fff;
      endcase
   endfunction

   // Random direction, biased toward ties, corners and small vectors
   task automatic pick_dir(output logic signed [DIR_BITS-1:0] x,
                           output logic signed [DIR_BITS-1:0] y,
                           output logic signed [DIR_BITS-1:0] z);
      int m;
      x = DIR_BITS'($urandom);
      y = DIR_BITS'($urandom);
      z = DIR_BITS'($urandom);
      case ($urandom_range(0, 9))
         5: begin
            x = corner_component();
            y = corner_component();
            z = corner_component();
         end
         6: begin
            // equal magnitudes on two or three axes
            m = $urandom_range(1, 32767);
            x = $urandom_range(0, 1) ? DIR_BITS'(m) : DIR_BITS'(-m);
            y = $urandom_range(0, 1) ? DIR_BITS'(m) : DIR_BITS'(-m);
            z = $urandom_range(0, 1) ? DIR_BITS'(m) : DIR_BITS'(int'($urandom_range(0, m)));
            if ($urandom_range(0, 1)) begin
               z = x;
               x = DIR_BITS'(-int'($urandom_range(0, m)));
            end
         end
         7: begin
            x = DIR_BITS'(int'($urandom_range(0, 6)) - 3);
            y = DIR_BITS'(int'($urandom_range(0, 6)) - 3);
            z = DIR_BITS'(int'($urandom_range(0, 6)) - 3);
         end
         8: begin
            // single axis, sometimes the zero vector
            case ($urandom_range(0, 3))
               0:       begin y = '0; z = '0; end
               1:       begin x = '0; z = '0; end
               2:       begin x = '0; y = '0; end
               default: begin x = '0; y = '0; z = '0; end
            endcase
         end
         default: ;
      endcase
   endtask

   // Zero vector, every face, axis extremes, ties and edge texels
   task automatic test_directed_vectors();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      send_dir(16'sd0, 16'sd0, 16'sd0);
      send_dir(16'sh7fff, 16'sd0, 16'sd0);
      send_dir(16'sh8000, 16'sd0, 16'sd0);
      send_dir(16'sd0, 16'sh7fff, 16'sd0);
      send_dir(16'sd0, 16'sh8000, 16'sd0);
      send_dir(16'sd0, 16'sd0, 16'sh7fff);
      send_dir(16'sd0, 16'sd0, 16'sh8000);
      send_dir(16'sd1, 16'sd1, 16'sd1);
      send_dir(-16'sd1, -16'sd1, -16'sd1);
      send_dir(16'sd0, 16'sd5, -16'sd5);
      send_dir(16'sd0, -16'sd5, 16'sd5);
      send_dir(16'sd7, 16'sd0, 16'sd7);
      send_dir(-16'sd9, 16'sd0, -16'sd9);
      send_dir(16'sh8000, 16'sh8000, 16'sh8000);
      send_dir(16'sh8000, 16'sh7fff, 16'sh7fff);
      send_dir(16'sh7fff, 16'sh8000, 16'sh7fff);
      send_dir(16'sd100, 16'sd100, -16'sd100);
      send_dir(16'sh7fff, 16'sh7fff, 16'sh8001);
      send_dir(16'sd1, -16'sd1, 16'sd1);
      send_dir(16'sd0, 16'sd0, -16'sd1);
      send_dir(16'sh1234, -16'sh0fff, 16'sh4000);
      send_dir(-16'sh2222, 16'sh7000, -16'sh7000);
      drain_pipe();
   endtask

   // Random requests over size settings and idling and stall phases
   task automatic test_size_sweep();
      logic signed [DIR_BITS-1:0] x, y, z;
      logic [SIZE_BITS-1:0]       height, width;
      for (int chunk = 0; chunk < 8; chunk++) begin
         case (chunk)
            0:       begin height = 13'd3;    width = 13'd3;    end
            1:       begin height = 13'd4096; width = 13'd4096; end
            2:       begin height = 13'd0;    width = 13'd8191; end
            3:       begin height = 13'd2;    width = 13'd4097; end
            4:       begin height = 13'd8191; width = 13'd1;    end
            5: begin
               height = SIZE_BITS'($urandom_range(3, 4096));
               width  = SIZE_BITS'($urandom_range(3, 4096));
            end
            6: begin
               height = SIZE_BITS'($urandom_range(0, 8191));
               width  = SIZE_BITS'($urandom_range(0, 8191));
            end
            default: begin height = 13'd258; width = 13'd3; end
         endcase
         write_size(CSR_FACE_HEIGHT, height);
         write_size(CSR_FACE_WIDTH, width);
         case (chunk % 4)
            0:       begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin req_idle_pct = 68; rsp_stall_pct = 0;  end
            2:       begin req_idle_pct = 0;  rsp_stall_pct = 68; end
            default: begin req_idle_pct = 21; rsp_stall_pct = 21; end
         endcase
         for (int n = 0; n < SWEEP_CHUNK; n++) begin
            pick_dir(x, y, z);
            send_dir(x, y, z);
         end
         drain_pipe();
      end
   endtask

   // Sender holds off until every response is back, then resumes
   task automatic test_drain_holdoff();
      logic signed [DIR_BITS-1:0] x, y, z;
      write_size(CSR_FACE_HEIGHT, SIZE_BITS'($urandom_range(3, 600)));
      write_size(CSR_FACE_WIDTH, SIZE_BITS'($urandom_range(3, 600)));
      req_idle_pct  = 21;
      rsp_stall_pct = 21;
      for (int burst = 0; burst < 3; burst++) begin
         for (int n = 0; n < 15; n++) begin
            pick_dir(x, y, z);
            send_dir(x, y, z);
         end
         drain_pipe();
      end
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed_vectors();
      test_size_sweep();
      test_drain_holdoff();
      drain_pipe();
      repeat (2 * PIPE_LATENCY) @(posedge clock);
      if (mismatch_count == 0 && expected_texels.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
